>>> design/chss_pkg.sv
// Shared types and constants for the consistent-hash server selector.
// No dependencies; imported by chss_select and consistent_hash_server_select_core.
`default_nettype none

package chss_pkg;

   localparam int unsigned NUM_SERVERS = 3;
   localparam int unsigned POS_W       = 7;
   localparam int unsigned HASH_W      = 8;
   localparam int unsigned DIST_W      = 9;
   localparam int unsigned IDX_W       = 2;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [HASH_W-1:0] hash_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef enum logic [1:0] {
      CMD_LOOKUP    = 2'd0,
      CMD_MARK_DOWN = 2'd1,
      CMD_MARK_UP   = 2'd2
   } cmd_type;

   // Configuration register indexes
   localparam logic [1:0] REG_SERVER0_POS = 2'd0;
   localparam logic [1:0] REG_SERVER1_POS = 2'd1;
   localparam logic [1:0] REG_SERVER2_POS = 2'd2;

   localparam pos_type SERVER0_POS_RESET = 7'd0;
   localparam pos_type SERVER1_POS_RESET = 7'd30;
   localparam pos_type SERVER2_POS_RESET = 7'd60;

   // Outcome of one ring lookup
   typedef struct packed {
      logic    found;
      idx_type chosen;
   } sel_result_type;

endpackage

`default_nettype wire

>>> design/chss_select.sv
// Clockwise nearest-server pick on the hash ring.
// Depends on chss_pkg.
`default_nettype none

module chss_select #(
   parameter int unsigned RING_SIZE    = 90,
   parameter int unsigned SERVER_COUNT = 3
) (
   input  chss_pkg::hash_type       hash,
   input  chss_pkg::pos_type        pos_arr [chss_pkg::NUM_SERVERS],
   input  logic [SERVER_COUNT-1:0]  active_mask,
   output chss_pkg::sel_result_type result
);
   import chss_pkg::*;

   localparam logic [DIST_W-1:0] RING = DIST_W'(RING_SIZE);

   logic [DIST_W-1:0] cw_dist  [SERVER_COUNT];
   logic [DIST_W-1:0] best_dist;
   logic              have;
   idx_type           best_idx;

   // Distance of each server clockwise from the hash; off-ring positions get the ring size
   always_comb begin
      for (int j = 0; j < SERVER_COUNT; j++) begin
         if (DIST_W'(pos_arr[j]) >= RING) begin
            cw_dist[j] = RING;
         end else if (DIST_W'(pos_arr[j]) >= DIST_W'(hash)) begin
            cw_dist[j] = DIST_W'(pos_arr[j]) - DIST_W'(hash);
         end else begin
            cw_dist[j] = DIST_W'(pos_arr[j]) + RING - DIST_W'(hash);
         end
      end
   end

   // Strict less-than keeps the lowest index on ties
   always_comb begin
      have      = 1'b0;
      best_dist = '0;
      best_idx  = '0;
      for (int j = 0; j < SERVER_COUNT; j++) begin
         if (active_mask[j] && (!have || cw_dist[j] < best_dist)) begin
            have      = 1'b1;
            best_dist = cw_dist[j];
            best_idx  = IDX_W'(j);
         end
      end
      result.found  = have;
      result.chosen = best_idx;
   end

endmodule

`default_nettype wire

>>> design/consistent_hash_server_select_core.sv
// Consistent-hash server selector: lookup and mark-down/mark-up transactions.
// Depends on chss_pkg and chss_select.
// A request passes through the input register and then the result register before rsp_tvalid
// rises; a response stalled by rsp_tready holds both stages.
// Throughput: one transaction per cycle while rsp_tready does not stall the response; the only
// loop is the active-mask update in the input-register stage.
// Reset (synchronous, active high): pipeline empty, only server 0 active,
// server positions 0, 30 and 60.
`default_nettype none

module consistent_hash_server_select_core #(
   parameter int unsigned RING_SIZE    = 90,
   parameter int unsigned SERVER_COUNT = 3
) (
   input  logic        clock,
   input  logic        reset,

   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] client_octet, [9:8] target_server, [15:10] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd

   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] chosen_server, [8:2] ring_slot, [15:9] zero
   output logic [0:0]  rsp_tuser,   // [0] found

   // Configuration writes
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [6:0]  csr_wdata
);
   import chss_pkg::*;

   // Server ring positions
   pos_type pos_ff [NUM_SERVERS];
   pos_type pos_in [NUM_SERVERS];

   always_comb begin
      pos_in = pos_ff;
      if (csr_wen) begin
         case (csr_addr)
            REG_SERVER0_POS: pos_in[0] = csr_wdata;
            REG_SERVER1_POS: pos_in[1] = csr_wdata;
            REG_SERVER2_POS: pos_in[2] = csr_wdata;
            default:         pos_in    = pos_ff;   // drop writes past the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0] <= SERVER0_POS_RESET;
         pos_ff[1] <= SERVER1_POS_RESET;
         pos_ff[2] <= SERVER2_POS_RESET;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Input register stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_cmd_ff;
   logic [HASH_W-1:0]    s1_octet_ff;
   idx_type              s1_target_ff;
   logic                 s1_advance;
   logic                 req_accept;

   // Result register stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   idx_type              rsp_chosen_ff, rsp_chosen_in;
   pos_type              rsp_hash_ff, rsp_hash_in;

   // Advance the input stage whenever the result register is empty or being drained
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Hold the payload while stalled; capture on accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff    <= req_tuser;
         s1_octet_ff  <= req_tdata[7:0];
         s1_target_ff <= req_tdata[9:8];
      end
   end

   // Constant table: octet modulo ring size, built at elaboration
   hash_type hash_tbl [256];

   for (genvar k = 0; k < 256; k++) begin : g_hash_tbl
      assign hash_tbl[k] = HASH_W'(k % RING_SIZE);
   end

   hash_type s1_hash;
   assign s1_hash = hash_tbl[s1_octet_ff];

   // Active server mask
   logic [SERVER_COUNT-1:0] active_ff, active_in;
   logic [SERVER_COUNT-1:0] target_sel;

   always_comb begin
      for (int j = 0; j < SERVER_COUNT; j++) begin
         target_sel[j] = (s1_target_ff == IDX_W'(j));
      end
   end

   always_comb begin
      active_in = active_ff;
      if (s1_advance) begin
         case (s1_cmd_ff)
            CMD_MARK_DOWN: active_in = active_ff & ~target_sel;
            CMD_MARK_UP:   active_in = active_ff | target_sel;
            default:       active_in = active_ff;   // lookups and the unused code leave it
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= SERVER_COUNT'(1);
      end else begin
         active_ff <= active_in;
      end
   end

   // Ring lookup against the mask as it stands before this transaction
   sel_result_type sel_result;

   chss_select #(
      .RING_SIZE    (RING_SIZE),
      .SERVER_COUNT (SERVER_COUNT)
   ) u_select (
      .hash        (s1_hash),
      .pos_arr     (pos_ff),
      .active_mask (active_ff),
      .result      (sel_result)
   );

   // Mark and unused commands report not found with a zero hash
   always_comb begin
      rsp_valid_in  = s1_advance || (rsp_valid_ff && !rsp_tready);
      rsp_found_in  = rsp_found_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_hash_in   = rsp_hash_ff;
      if (s1_advance) begin
         if (s1_cmd_ff == CMD_LOOKUP) begin
            rsp_found_in  = sel_result.found;
            rsp_chosen_in = sel_result.chosen;
            rsp_hash_in   = s1_hash[POS_W-1:0];
         end else begin
            rsp_found_in  = 1'b0;
            rsp_chosen_in = '0;
            rsp_hash_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_hash_ff   <= rsp_hash_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_hash_ff, rsp_chosen_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

`default_nettype wire
